// File: hw/rtl/ssb_pkg.sv
// Shared types and constants of the scaled sprite pixel blitter.
package ssb_pkg;

  // Field widths of the item channels.
  localparam int unsigned TexelAddrW = 12;
  localparam int unsigned DestW      = 11;
  localparam int unsigned PosW       = 12;
  localparam int unsigned FrameW     = 8;
  localparam int unsigned ScreenYW   = 10;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [31:0]           texel_t;
  typedef logic [TexelAddrW-1:0] texel_addr_t;
  typedef logic [DestW-1:0]      dest_t;
  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [FrameW-1:0]     frame_t;
  typedef logic [ScreenYW-1:0]   screen_y_t;
  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [CfgDataW-1:0]   cfg_data_t;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHEET_WIDTH   = 3'd0,
    CFG_SHEET_HEIGHT  = 3'd1,
    CFG_FRAME_ROWS    = 3'd2,
    CFG_INVERSE_SCALE = 3'd3,
    CFG_SCALED_WIDTH  = 3'd4,
    CFG_SCALED_HEIGHT = 3'd5,
    CFG_X_SHIFT       = 3'd6
  } cfg_reg_t;

  // Item mode codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Color key: a texel is drawn only if one of these bits is set.
  localparam texel_t KEY_MASK = 32'h00FF00FF;

  // Register values after reset.
  localparam logic [12:0] RST_SHEET_WIDTH   = 13'd64;
  localparam logic [12:0] RST_SHEET_HEIGHT  = 13'd64;
  localparam logic [12:0] RST_FRAME_ROWS    = 13'd64;
  localparam logic [15:0] RST_INVERSE_SCALE = 16'd256;
  localparam logic [10:0] RST_SCALED_WIDTH  = 11'd64;
  localparam logic [10:0] RST_SCALED_HEIGHT = 11'd64;
  localparam logic [7:0]  RST_X_SHIFT       = 8'd75;

endpackage

// File: hw/rtl/ssb_in_if.sv
// Input item channel of the scaled sprite pixel blitter.
interface ssb_in_if;
  import ssb_pkg::*;

  logic        valid;
  logic        ready;
  logic        mode;
  texel_addr_t texel_addr;
  texel_t      texel_value;
  dest_t       dest_x;
  dest_t       dest_y;
  pos_t        pos_x;
  pos_t        pos_y;
  frame_t      frame_index;
  logic        shown;

  modport source (
    output valid, mode, texel_addr, texel_value, dest_x, dest_y, pos_x, pos_y,
           frame_index, shown,
    input  ready
  );

  modport sink (
    input  valid, mode, texel_addr, texel_value, dest_x, dest_y, pos_x, pos_y,
           frame_index, shown,
    output ready
  );
endinterface

// File: hw/rtl/ssb_out_if.sv
// Result item channel of the scaled sprite pixel blitter.
interface ssb_out_if;
  import ssb_pkg::*;

  logic      valid;
  logic      ready;
  logic      plot;
  pos_t      screen_x;
  screen_y_t screen_y;
  texel_t    pixel_color;

  modport source (
    output valid, plot, screen_x, screen_y, pixel_color,
    input  ready
  );

  modport sink (
    input  valid, plot, screen_x, screen_y, pixel_color,
    output ready
  );
endinterface

// File: hw/rtl/ssb_cfg_if.sv
// Configuration write channel of the scaled sprite pixel blitter.
interface ssb_cfg_if;
  import ssb_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hw/rtl/scaled_sprite_pixel_blitter_top.sv
// Top level of the scaled sprite pixel blitter: five-stage draw pipeline and texel memory.
//
// The block takes one item per clock cycle when the output side does not stall, and it
// returns exactly one result item for each item that it takes, in order. Stage one
// clips the destination offset and screen position and forms the three scale and frame
// products, stage two finishes the source coordinates and checks them against the sheet,
// stage three forms the linear texel address, stage four uses the single port of the
// texel memory (a load item writes there, a draw item reads there) and stage five applies
// the color key and the x shift into the output register. Each stage holds its item when
// the next one is full and stalled, so bubbles are squeezed out and in_ch.ready stays high
// while a result waits as long as an earlier stage is empty. Texels must be loaded before
// they are drawn; the memory is not cleared after reset. The configuration port is always
// ready and must only be written while no item is in flight.
module scaled_sprite_pixel_blitter_top #(
  parameter int WINDOW_WIDTH  = 1024,
  parameter int WINDOW_HEIGHT = 768,
  parameter int TEXEL_DEPTH   = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  ssb_in_if.sink       in_ch,
  ssb_out_if.source    out_ch,
  ssb_cfg_if.sink      cfg_ch
);
  import ssb_pkg::*;

  localparam int          AddrW    = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam logic [12:0] WinW     = 13'(WINDOW_WIDTH);
  localparam logic [12:0] WinH     = 13'(WINDOW_HEIGHT);
  localparam logic [26:0] DepthLim = 27'(TEXEL_DEPTH);

  // Configuration registers.
  logic [12:0] sheet_width_r;
  logic [12:0] sheet_height_r;
  logic [12:0] frame_rows_r;
  logic [15:0] inverse_scale_r;
  logic [10:0] scaled_width_r;
  logic [10:0] scaled_height_r;
  logic [7:0]  x_shift_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_width_r   <= RST_SHEET_WIDTH;
      sheet_height_r  <= RST_SHEET_HEIGHT;
      frame_rows_r    <= RST_FRAME_ROWS;
      inverse_scale_r <= RST_INVERSE_SCALE;
      scaled_width_r  <= RST_SCALED_WIDTH;
      scaled_height_r <= RST_SCALED_HEIGHT;
      x_shift_r       <= RST_X_SHIFT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SHEET_WIDTH:   sheet_width_r   <= cfg_ch.data[12:0];
        CFG_SHEET_HEIGHT:  sheet_height_r  <= cfg_ch.data[12:0];
        CFG_FRAME_ROWS:    frame_rows_r    <= cfg_ch.data[12:0];
        CFG_INVERSE_SCALE: inverse_scale_r <= cfg_ch.data;
        CFG_SCALED_WIDTH:  scaled_width_r  <= cfg_ch.data[10:0];
        CFG_SCALED_HEIGHT: scaled_height_r <= cfg_ch.data[10:0];
        CFG_X_SHIFT:       x_shift_r       <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the output register.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;

  // A stage loads when it is empty or its item moves on in the same cycle.
  assign en_out = !out_valid_r || out_ch.ready;
  assign en4    = !v4_r || en_out;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_ch.valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // Stage one: clipping, screen position and the three products.
  logic [12:0] sx_nxt, sy_nxt;
  logic [26:0] prod_x_nxt, prod_y_nxt;
  logic [20:0] prod_f_nxt;
  logic        ok1_nxt, wr1_nxt;

  always_comb begin
    sx_nxt     = {in_ch.pos_x[11], in_ch.pos_x} + {2'b00, in_ch.dest_x};
    sy_nxt     = {in_ch.pos_y[11], in_ch.pos_y} + {2'b00, in_ch.dest_y};
    prod_x_nxt = {16'd0, in_ch.dest_x} * {11'd0, inverse_scale_r};
    prod_y_nxt = {16'd0, in_ch.dest_y} * {11'd0, inverse_scale_r};
    prod_f_nxt = {13'd0, in_ch.frame_index} * {8'd0, frame_rows_r};
    ok1_nxt    = (in_ch.mode == MODE_DRAW) && in_ch.shown
                 && (in_ch.dest_x < scaled_width_r) && (in_ch.dest_y < scaled_height_r)
                 && !sx_nxt[12] && (sx_nxt < WinW)
                 && !sy_nxt[12] && (sy_nxt < WinH);
    wr1_nxt    = (in_ch.mode == MODE_LOAD) && ({15'd0, in_ch.texel_addr} < DepthLim);
  end

  logic        ok1_r, wr1_r;
  logic [26:0] prod_x1_r, prod_y1_r;
  logic [20:0] prod_f1_r;
  logic [12:0] sx1_r, sy1_r;
  texel_addr_t taddr1_r;
  texel_t      tval1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1_r     <= ok1_nxt;
      wr1_r     <= wr1_nxt;
      prod_x1_r <= prod_x_nxt;
      prod_y1_r <= prod_y_nxt;
      prod_f1_r <= prod_f_nxt;
      sx1_r     <= sx_nxt;
      sy1_r     <= sy_nxt;
      taddr1_r  <= in_ch.texel_addr;
      tval1_r   <= in_ch.texel_value;
    end
  end

  // Stage two: source coordinates and the sheet bounds check.
  logic [18:0] src_x_nxt;
  logic [21:0] src_y_nxt;
  logic        ok2_nxt;

  always_comb begin
    src_x_nxt = prod_x1_r[26:8];
    src_y_nxt = {3'd0, prod_y1_r[26:8]} + {1'b0, prod_f1_r};
    ok2_nxt   = ok1_r && (src_x_nxt < {6'd0, sheet_width_r})
                && (src_y_nxt < {9'd0, sheet_height_r});
  end

  logic        ok2_r, wr2_r;
  logic [12:0] src_x2_r, src_y2_r, sx2_r, sy2_r;
  texel_addr_t taddr2_r;
  texel_t      tval2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ok2_r    <= ok2_nxt;
      wr2_r    <= wr1_r;
      src_x2_r <= src_x_nxt[12:0];
      src_y2_r <= src_y_nxt[12:0];
      sx2_r    <= sx1_r;
      sy2_r    <= sy1_r;
      taddr2_r <= taddr1_r;
      tval2_r  <= tval1_r;
    end
  end

  // Stage three: linear texel address.
  logic [26:0] addr_nxt;

  assign addr_nxt = ({14'd0, src_y2_r} * {14'd0, sheet_width_r}) + {14'd0, src_x2_r};

  logic        ok3_r, wr3_r;
  logic [26:0] addr3_r;
  logic [12:0] sx3_r, sy3_r;
  texel_addr_t taddr3_r;
  texel_t      tval3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      ok3_r    <= ok2_r;
      wr3_r    <= wr2_r;
      addr3_r  <= addr_nxt;
      sx3_r    <= sx2_r;
      sy3_r    <= sy2_r;
      taddr3_r <= taddr2_r;
      tval3_r  <= tval2_r;
    end
  end

  // Stage four: texel memory, written by load items and read by draw items.
  texel_t      texel_mem [TEXEL_DEPTH];
  texel_t      rdata4_r;
  logic        ok4_r;
  logic [12:0] sx4_r, sy4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      if (v3_r && wr3_r) begin
        texel_mem[AddrW'(taddr3_r)] <= tval3_r;
      end
      rdata4_r <= texel_mem[AddrW'(addr3_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ok4_r <= ok3_r && (addr3_r < DepthLim);
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
    end
  end

  // Stage five: color key, x shift and the result register.
  logic        plot_nxt;
  logic [12:0] shifted_nxt;

  always_comb begin
    plot_nxt    = ok4_r && ((rdata4_r & KEY_MASK) != '0);
    shifted_nxt = sx4_r - {5'd0, x_shift_r};
  end

  logic      plot_r;
  pos_t      screen_x_r;
  screen_y_t screen_y_r;
  texel_t    pixel_color_r;

  always_ff @(posedge clk) begin
    if (en_out) begin
      plot_r        <= plot_nxt;
      screen_x_r    <= plot_nxt ? shifted_nxt[11:0] : '0;
      screen_y_r    <= plot_nxt ? sy4_r[9:0] : '0;
      pixel_color_r <= plot_nxt ? rdata4_r : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.plot        = plot_r;
  assign out_ch.screen_x    = screen_x_r;
  assign out_ch.screen_y    = screen_y_r;
  assign out_ch.pixel_color = pixel_color_r;

endmodule

// File: hw/rtl/ssb_checker.sv
// Port-level checker of the scaled sprite pixel blitter and its bind to the top level.
module ssb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               plot,
  input ssb_pkg::pos_t      screen_x,
  input ssb_pkg::screen_y_t screen_y,
  input ssb_pkg::texel_t    pixel_color
);
  import ssb_pkg::*;

  // A stalled result item stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(plot) && $stable(screen_x)
      && $stable(screen_y) && $stable(pixel_color))
    else $error("stalled result item changed");

  // An item without a plot carries an all-zero payload.
  a_no_plot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !plot |-> screen_x == '0 && screen_y == '0 && pixel_color == '0)
    else $error("non-plot result item has nonzero payload");

  // A plotted color always passes the color key.
  a_plot_keyed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && plot |-> (pixel_color & KEY_MASK) != '0)
    else $error("plotted color fails the color key");

endmodule

bind scaled_sprite_pixel_blitter_top ssb_checker u_ssb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .plot        (out_ch.plot),
  .screen_x    (out_ch.screen_x),
  .screen_y    (out_ch.screen_y),
  .pixel_color (out_ch.pixel_color)
);
